// File: sv/gsg_pkg.sv
// package for the three-axis grid scan generator
// holds field widths, op and register codes, controller state and command/status structs
// no dependencies
package gsg_pkg;

    localparam int POS_W   = 32;
    localparam int COUNT_W = 13;
    localparam int AXES    = 3;

    // op codes carried in s_tuser
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_ABORT   = 2'd2;

    // register indexes on the config port
    localparam logic [2:0] REG_X_LOWER = 3'd0;
    localparam logic [2:0] REG_X_UPPER = 3'd1;
    localparam logic [2:0] REG_Y_LOWER = 3'd2;
    localparam logic [2:0] REG_Y_UPPER = 3'd3;
    localparam logic [2:0] REG_Z_LOWER = 3'd4;
    localparam logic [2:0] REG_Z_UPPER = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT
    } gsg_state_t;

    typedef struct packed {
        logic       load;
        logic       advance;
        logic       abort;
        logic       div_start;
        logic       div_store;
        logic [1:0] axis;
    } gsg_cmd_t;

    typedef struct packed {
        logic out_stall;
        logic div_done;
    } gsg_status_t;

endpackage

// File: sv/three_axis_grid_scan_generator.sv
// top level of the three-axis grid scan generator: ports, field unpacking, submodules
// depends on gsg_pkg, gsg_regs, gsg_ctrl, gsg_dpath (and gsg_div below it)
//
//  channel   direction  handshake                 contents
//  s_axis    in         s_tvalid / s_tready       op in tuser, start/end/count in tdata
//  m_axis    out        m_tvalid / m_tready       grid point in tdata, last point on tlast
//  apb       in         psel / penable, pready=1  six bound registers, 4-byte stride
//
// advance and abort words need no division; advance words stream at one per cycle while m_axis is not stalled
// a load word runs one serial 32-step division per axis on a shared divider
// s_tready is low while the divider runs and while a point waits on m_tready with m_tvalid high
// reset is synchronous on aresetn low and clears the scan and the bounds to 0
module three_axis_grid_scan_generator #(
    parameter int MAX_AXIS_POINTS = 4096
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // x_start, y_start, z_start, x_end, y_end, z_end, x_count, y_count, z_count, pad
    input  logic [231:0] s_tdata,
    // op
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // x_pos, y_pos, z_pos
    output logic [95:0]  m_tdata,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import gsg_pkg::*;

    logic [AXES-1:0][POS_W-1:0]   lower_bound, upper_bound;
    logic [AXES-1:0][POS_W-1:0]   start_pos, end_pos, out_pos;
    logic [AXES-1:0][COUNT_W-1:0] count;
    gsg_cmd_t                     cmd;
    gsg_status_t                  status;

    for (genvar a = 0; a < AXES; a++) begin : g_unpack
        assign start_pos[a] = s_tdata[a*POS_W +: POS_W];
        assign end_pos[a]   = s_tdata[(AXES + a)*POS_W +: POS_W];
        assign count[a]     = s_tdata[2*AXES*POS_W + a*COUNT_W +: COUNT_W];
        assign m_tdata[a*POS_W +: POS_W] = out_pos[a];
    end

    assign pready = 1'b1;

    gsg_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound)
    );

    gsg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gsg_dpath #(
        .MAX_AXIS_POINTS(MAX_AXIS_POINTS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound),
        .start_pos   (start_pos),
        .end_pos     (end_pos),
        .count       (count),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_pos     (out_pos),
        .out_last    (m_tlast)
    );

endmodule

// File: sv/gsg_regs.sv
// bound registers of the grid scan generator behind an apb-style port
// depends on gsg_pkg
module gsg_regs (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [4:0]                                  paddr,
    input  logic [31:0]                                 pwdata,
    output logic [31:0]                                 prdata,
    output logic [gsg_pkg::AXES-1:0][gsg_pkg::POS_W-1:0] lower_bound,
    output logic [gsg_pkg::AXES-1:0][gsg_pkg::POS_W-1:0] upper_bound
);
    import gsg_pkg::*;

    logic [AXES-1:0][POS_W-1:0] lower_reg, lower_next;
    logic [AXES-1:0][POS_W-1:0] upper_reg, upper_next;
    logic                       wr_en;
    logic [2:0]                 reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_comb begin
        lower_next = lower_reg;
        upper_next = upper_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_X_LOWER: lower_next[0] = pwdata;
                REG_X_UPPER: upper_next[0] = pwdata;
                REG_Y_LOWER: lower_next[1] = pwdata;
                REG_Y_UPPER: upper_next[1] = pwdata;
                REG_Z_LOWER: lower_next[2] = pwdata;
                REG_Z_UPPER: upper_next[2] = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg <= '0;
            upper_reg <= '0;
        end else begin
            lower_reg <= lower_next;
            upper_reg <= upper_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_X_LOWER: prdata = lower_reg[0];
            REG_X_UPPER: prdata = upper_reg[0];
            REG_Y_LOWER: prdata = lower_reg[1];
            REG_Y_UPPER: prdata = upper_reg[1];
            REG_Z_LOWER: prdata = lower_reg[2];
            REG_Z_UPPER: prdata = upper_reg[2];
            default:     prdata = '0;
        endcase
    end

    assign lower_bound = lower_reg;
    assign upper_bound = upper_reg;

endmodule

// File: sv/gsg_div.sv
// restoring divider, one quotient bit per cycle, for the per-axis step size
// depends on gsg_pkg
module gsg_div #(
    parameter int DIVISOR_W = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [gsg_pkg::POS_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]      divisor,
    output logic                      done,
    output logic [gsg_pkg::POS_W-1:0] quotient
);
    import gsg_pkg::*;

    localparam int CNT_W = $clog2(POS_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [POS_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;
    logic                 last_step;

    assign trial     = {rem_reg, quo_reg[POS_W-1]};
    assign fits      = trial >= {1'b0, dsr_reg};
    assign last_step = cnt_reg == CNT_W'(POS_W - 1);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[POS_W-2:0], fits};
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, dsr_reg}) : DIVISOR_W'(trial);
            cnt_next = cnt_reg + CNT_W'(1);
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/gsg_dpath.sv
// datapath: axis clamping, scan grid state, point stepping and the output register
// depends on gsg_pkg and gsg_div
module gsg_dpath #(
    parameter int MAX_AXIS_POINTS = 4096
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  gsg_pkg::gsg_cmd_t                            cmd,
    output gsg_pkg::gsg_status_t                         status,
    input  logic [gsg_pkg::AXES-1:0][gsg_pkg::POS_W-1:0]  lower_bound,
    input  logic [gsg_pkg::AXES-1:0][gsg_pkg::POS_W-1:0]  upper_bound,
    input  logic [gsg_pkg::AXES-1:0][gsg_pkg::POS_W-1:0]  start_pos,
    input  logic [gsg_pkg::AXES-1:0][gsg_pkg::POS_W-1:0]  end_pos,
    input  logic [gsg_pkg::AXES-1:0][gsg_pkg::COUNT_W-1:0] count,
    input  logic                                         out_ready,
    output logic                                         out_valid,
    output logic [gsg_pkg::AXES-1:0][gsg_pkg::POS_W-1:0]  out_pos,
    output logic                                         out_last
);
    import gsg_pkg::*;

    localparam int IDX_W = $clog2(MAX_AXIS_POINTS);
    localparam int TOT_W = $clog2(MAX_AXIS_POINTS + 1);
    localparam int CMP_W = (TOT_W > COUNT_W) ? TOT_W : COUNT_W;

    logic [AXES-1:0][POS_W-1:0] origin_reg, cur_reg, inc_reg, mag_reg;
    logic [AXES-1:0][TOT_W-1:0] tot_reg;
    logic [AXES-1:0][IDX_W-1:0] idx_reg;
    logic [AXES-1:0]            neg_reg;
    logic                       active_reg, active_next;
    logic                       valid_reg, valid_next;
    logic [AXES-1:0][POS_W-1:0] pos_reg;
    logic                       last_reg;

    logic [AXES-1:0][POS_W-1:0] s_clamp, e_clamp, s_low, e_low;
    logic [AXES-1:0][TOT_W-1:0] n_sat;
    logic [AXES-1:0]            at_end, step_en;
    logic                       scan_last, emit;
    logic [POS_W-1:0]           div_q;
    logic                       div_done;
    logic [TOT_W-1:0]           sel_tot;
    logic [IDX_W-1:0]           sel_dsr;

    assign emit      = cmd.advance && active_reg;
    assign scan_last = &at_end;

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        logic [TOT_W-1:0] idx_inc;
        logic [CMP_W-1:0] cnt_ext;

        // lower bound first, then upper bound wins
        assign s_low[a]   = ($signed(start_pos[a]) < $signed(lower_bound[a]))
                            ? lower_bound[a] : start_pos[a];
        assign s_clamp[a] = ($signed(s_low[a]) > $signed(upper_bound[a]))
                            ? upper_bound[a] : s_low[a];
        assign e_low[a]   = ($signed(end_pos[a]) < $signed(lower_bound[a]))
                            ? lower_bound[a] : end_pos[a];
        assign e_clamp[a] = ($signed(e_low[a]) > $signed(upper_bound[a]))
                            ? upper_bound[a] : e_low[a];

        assign cnt_ext  = CMP_W'(count[a]);
        assign n_sat[a] = (cnt_ext < CMP_W'(2)) ? TOT_W'(1)
                        : (cnt_ext > CMP_W'(MAX_AXIS_POINTS)) ? TOT_W'(MAX_AXIS_POINTS)
                        : TOT_W'(count[a]);

        assign idx_inc   = TOT_W'(idx_reg[a]) + TOT_W'(1);
        assign at_end[a] = idx_inc >= tot_reg[a];

        always_ff @(posedge aclk) begin
            if (cmd.load) begin
                origin_reg[a] <= s_clamp[a];
                cur_reg[a]    <= s_clamp[a];
                tot_reg[a]    <= n_sat[a];
                idx_reg[a]    <= '0;
                neg_reg[a]    <= $signed(e_clamp[a]) < $signed(s_clamp[a]);
                mag_reg[a]    <= ($signed(e_clamp[a]) < $signed(s_clamp[a]))
                                 ? s_clamp[a] - e_clamp[a] : e_clamp[a] - s_clamp[a];
            end else if (step_en[a]) begin
                if (at_end[a]) begin
                    idx_reg[a] <= '0;
                    cur_reg[a] <= origin_reg[a];
                end else begin
                    idx_reg[a] <= IDX_W'(idx_inc);
                    cur_reg[a] <= cur_reg[a] + inc_reg[a];
                end
            end
            if (cmd.div_store && cmd.axis == 2'(a)) begin
                if (tot_reg[a] < TOT_W'(2)) begin
                    inc_reg[a] <= '0;
                end else begin
                    inc_reg[a] <= neg_reg[a] ? (~div_q + POS_W'(1)) : div_q;
                end
            end
        end
    end

    // z steps on every point but the last, y when z wraps, x when y wraps
    assign step_en[2] = emit && !scan_last;
    assign step_en[1] = step_en[2] && at_end[2];
    assign step_en[0] = step_en[1] && at_end[1];

    assign sel_tot = tot_reg[cmd.axis];
    assign sel_dsr = IDX_W'(sel_tot - TOT_W'(1));

    gsg_div #(
        .DIVISOR_W(IDX_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (mag_reg[cmd.axis]),
        .divisor  (sel_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        active_next = active_reg;
        if (cmd.load) begin
            active_next = 1'b1;
        end else if (cmd.abort) begin
            active_next = 1'b0;
        end else if (emit && scan_last) begin
            active_next = 1'b0;
        end
        valid_next = valid_reg;
        if (emit) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            pos_reg  <= cur_reg;
            last_reg <= scan_last;
        end
    end

    assign status.out_stall = valid_reg && !out_ready;
    assign status.div_done  = div_done;
    assign out_valid        = valid_reg;
    assign out_pos          = pos_reg;
    assign out_last         = last_reg;

endmodule

// File: sv/gsg_ctrl.sv
// controller: input handshake, op decode and sequencing of the step divisions
// depends on gsg_pkg
module gsg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [1:0]           in_op,
    output logic                 in_ready,
    input  gsg_pkg::gsg_status_t status,
    output gsg_pkg::gsg_cmd_t    cmd
);
    import gsg_pkg::*;

    gsg_state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       accept;

    assign accept = in_valid && in_ready;

    always_comb begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.axis      = axis_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready    = !status.out_stall;
                cmd.load    = accept && in_op == OP_LOAD;
                cmd.advance = accept && in_op == OP_ADVANCE;
                cmd.abort   = accept && in_op == OP_ABORT;
                if (accept && in_op == OP_LOAD) begin
                    axis_next  = AXIS_X;
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.div_store = 1'b1;
                    if (axis_reg == AXIS_Z) begin
                        state_next = ST_IDLE;
                    end else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= AXIS_X;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

// File: test/tb_top.sv
// testbench for three_axis_grid_scan_generator: loads, advances and aborts, bound writes
// a scoreboard class predicts each grid point and checks the m_axis words in order
// depends on gsg_pkg and the three_axis_grid_scan_generator rtl
module tb_top;
    import gsg_pkg::*;

    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [2:0]  REG_SPARE_LO = 3'd6;
    localparam logic [2:0]  REG_SPARE_HI = 3'd7;
    localparam logic [31:0] POS_MIN      = 32'h8000_0000;
    localparam logic [31:0] POS_MAX      = 32'h7fff_ffff;
    localparam int          AXIS_LIMIT   = 4096;
    localparam int          WORDS_PER_PHASE = 108;
    localparam int          NUM_PHASES   = 7;
    localparam int          SETTLE_CYCLES = 120;
    localparam int          STALL_LIMIT  = 2000;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] first [3];
        logic [31:0] stop  [3];
        logic [12:0] count [3];
    } scan_word_t;

    typedef struct {
        logic [31:0] pos [3];
        logic        last;
    } grid_point_t;

    class grid_point_checker;
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
        logic signed [31:0] origin [3];
        logic signed [31:0] incr [3];
        logic signed [31:0] cur [3];
        int unsigned        total [3];
        int unsigned        idx [3];
        bit                 active;
        grid_point_t        points_due [$];
        int                 mismatches;

        function new();
            for (int i = 0; i < 3; i++) begin
                lo[i] = 0; hi[i] = 0; origin[i] = 0; incr[i] = 0; cur[i] = 0;
                total[i] = 0; idx[i] = 0;
            end
            active = 0;
            mismatches = 0;
        endfunction

        function void set_bound(logic [2:0] reg_idx, logic [31:0] value);
            case (reg_idx)
                REG_X_LOWER: lo[0] = value;
                REG_X_UPPER: hi[0] = value;
                REG_Y_LOWER: lo[1] = value;
                REG_Y_UPPER: hi[1] = value;
                REG_Z_LOWER: lo[2] = value;
                REG_Z_UPPER: hi[2] = value;
                default: ;
            endcase
        endfunction

        function logic signed [31:0] clamp(logic signed [31:0] v, int a);
            if (v < lo[a]) v = lo[a];
            if (v > hi[a]) v = hi[a];
            return v;
        endfunction

        // returns 1 when the axis wrapped back to its origin
        function bit step_axis(int a);
            if (idx[a] + 1 >= total[a]) begin
                idx[a] = 0;
                cur[a] = origin[a];
                return 1;
            end
            idx[a]++;
            cur[a] = cur[a] + incr[a];
            return 0;
        endfunction

        function void note_word(scan_word_t w);
            logic signed [31:0] s, e;
            longint             diff, mag;
            grid_point_t        p;
            case (w.op)
                OP_LOAD: begin
                    for (int i = 0; i < 3; i++) begin
                        s = clamp(w.first[i], i);
                        e = clamp(w.stop[i], i);
                        if (w.count[i] < 2) total[i] = 1;
                        else if (w.count[i] > AXIS_LIMIT) total[i] = AXIS_LIMIT;
                        else total[i] = 32'(w.count[i]);
                        origin[i] = s;
                        cur[i] = s;
                        idx[i] = 0;
                        if (total[i] < 2) begin
                            incr[i] = 0;
                        end else begin
                            // truncate toward zero
                            diff = longint'(e) - longint'(s);
                            mag = ((diff < 0) ? -diff : diff) / longint'(total[i] - 1);
                            incr[i] = 32'((diff < 0) ? -mag : mag);
                        end
                    end
                    active = 1;
                end
                OP_ABORT: active = 0;
                OP_ADVANCE: begin
                    if (active) begin
                        p.last = 1;
                        for (int i = 0; i < 3; i++) begin
                            p.pos[i] = cur[i];
                            if (idx[i] + 1 < total[i]) p.last = 0;
                        end
                        points_due.insert(points_due.size(), p);
                        if (p.last) active = 0;
                        else if (step_axis(2)) begin
                            if (step_axis(1)) void'(step_axis(0));
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                  logic last);
            grid_point_t want;
            logic [31:0] got [3];
            got[0] = x; got[1] = y; got[2] = z;
            if (points_due.size() == 0) begin
                $display("%0t: unexpected point x=%h y=%h z=%h last=%b",
                         $time, x, y, z, last);
                mismatches++;
                return;
            end
            want = points_due.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (got[i] !== want.pos[i]) begin
                    $display("%0t: axis %0d position expected %h actual %h",
                             $time, i, want.pos[i], got[i]);
                    mismatches++;
                end
            end
            if (last !== want.last) begin
                $display("%0t: last point expected %b actual %b", $time, want.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return points_due.size();
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [231:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic         m_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    grid_point_checker sb = new();
    int send_idle_pct = 32;
    int recv_idle_pct = 48;
    int words_sent = 0;
    int stall_cycles = 0;

    three_axis_grid_scan_generator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready) begin
            sb.check_point(m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tlast);
        end
    end

    // no word moving on either side for too long means the block hung
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // all tasks start and end at a falling edge
    task automatic send_word(scan_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tuser = w.op;
        s_tdata = '0;
        for (int i = 0; i < 3; i++) begin
            s_tdata[32*i +: 32]      = w.first[i];
            s_tdata[96 + 32*i +: 32] = w.stop[i];
            s_tdata[192 + 13*i +: 13] = w.count[i];
        end
        s_tvalid = 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_word(w);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic apb_write(logic [2:0] reg_idx, logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_idx, 2'b00};
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        sb.set_bound(reg_idx, value);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // loads can still be dividing after the last point came out
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic scan_word_t load_word(logic [31:0] s0, s1, s2, e0, e1, e2,
                                             logic [12:0] c0, c1, c2);
        scan_word_t w;
        w.op = OP_LOAD;
        w.first[0] = s0; w.first[1] = s1; w.first[2] = s2;
        w.stop[0] = e0;  w.stop[1] = e1;  w.stop[2] = e2;
        w.count[0] = c0; w.count[1] = c1; w.count[2] = c2;
        return w;
    endfunction

    function automatic scan_word_t op_word(logic [1:0] op);
        scan_word_t w;
        w.op = op;
        for (int i = 0; i < 3; i++) begin
            w.first[i] = $urandom;
            w.stop[i] = $urandom;
            w.count[i] = 13'($urandom);
        end
        return w;
    endfunction

    function automatic logic [31:0] pick_pos(logic signed [31:0] lo, logic signed [31:0] hi);
        int      r;
        longint  span;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 5))
                0: return POS_MIN;
                1: return POS_MAX;
                2: return 32'd0;
                3: return lo;
                4: return hi;
                default: return 32'hffff_ffff;
            endcase
        end
        if (r < 45 || lo > hi) return $urandom;
        span = longint'(hi) - longint'(lo) + 1;
        return 32'(lo + ((longint'({$urandom, $urandom}) & 64'h7fff_ffff_ffff_ffff) % span));
    endfunction

    function automatic logic [12:0] pick_count(bit big);
        if (!big) return 13'($urandom_range(0, 4));
        if ($urandom_range(0, 1)) return 13'($urandom_range(5, AXIS_LIMIT));
        return 13'($urandom_range(AXIS_LIMIT + 1, 8191));
    endfunction

    function automatic int axis_points(logic [12:0] c);
        if (c < 2) return 1;
        if (c > AXIS_LIMIT) return AXIS_LIMIT;
        return int'(c);
    endfunction

    function automatic scan_word_t random_load(bit big);
        scan_word_t w;
        int         big_axis;
        big_axis = $urandom_range(0, 2);
        w.op = OP_LOAD;
        for (int i = 0; i < 3; i++) begin
            w.first[i] = pick_pos(sb.lo[i], sb.hi[i]);
            w.stop[i] = pick_pos(sb.lo[i], sb.hi[i]);
            w.count[i] = pick_count(big && i == big_axis);
        end
        return w;
    endfunction

    // mostly complete scans, sometimes cut short, sometimes plain noise
    task automatic run_sequence();
        scan_word_t w;
        int         points, steps;
        logic [1:0] cut_op;
        if ($urandom_range(0, 99) < 75) begin
            w = random_load($urandom_range(0, 9) == 0);
            send_word(w);
            points = axis_points(w.count[0]) * axis_points(w.count[1]) *
                     axis_points(w.count[2]);
            steps = (points > 64) ? $urandom_range(1, 20) : points;
            if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps);
            repeat (steps) send_word(op_word(OP_ADVANCE));
            if (steps < points) begin
                case ($urandom_range(0, 2))
                    0: cut_op = OP_ABORT;
                    1: cut_op = OP_UNUSED;
                    default: cut_op = OP_LOAD;
                endcase
                if (cut_op == OP_LOAD) send_word(random_load(0));
                else send_word(op_word(cut_op));
            end else if ($urandom_range(0, 4) == 0) begin
                send_word(op_word(OP_ADVANCE));
            end
        end else begin
            repeat ($urandom_range(1, 4)) begin
                w = op_word(2'($urandom_range(0, 3)));
                if (w.op == OP_LOAD) w = random_load(0);
                send_word(w);
            end
        end
    endtask

    task automatic directed_words();
        send_word(load_word(POS_MIN, POS_MAX, 0, POS_MAX, POS_MIN, 1, 3, 2, 0));
        repeat (7) send_word(op_word(OP_ADVANCE));
        // single point scan is last right away
        send_word(load_word(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN, 1, 1, 1));
        send_word(op_word(OP_ADVANCE));
        // counts past the axis limit saturate
        send_word(load_word(0, 32'hffff_ffff, POS_MIN, 0, 1, POS_MAX, 8191, 4096, 13'h1fff));
        send_word(op_word(OP_UNUSED));
        repeat (3) send_word(op_word(OP_ADVANCE));
        // reload in the middle of a scan
        send_word(load_word(1, 2, 3, 5, 7, 32'hffff_fff7, 2, 1, 1));
        repeat (2) send_word(op_word(OP_ADVANCE));
        send_word(load_word(POS_MIN, 0, POS_MAX, POS_MAX, 0, POS_MIN, 2, 2, 2));
        send_word(op_word(OP_ADVANCE));
        send_word(op_word(OP_ABORT));
        send_word(op_word(OP_ADVANCE));
    endtask

    task automatic set_bounds(int phase);
        logic [31:0] a, b;
        logic signed [31:0] base;
        for (int i = 0; i < 3; i++) begin
            a = $urandom;
            b = $urandom;
            case (phase)
                1: begin
                    apb_write(3'(2*i), POS_MIN);
                    apb_write(3'(2*i + 1), POS_MAX);
                end
                2: begin
                    apb_write(3'(2*i), ($signed(a) < $signed(b)) ? a : b);
                    apb_write(3'(2*i + 1), ($signed(a) < $signed(b)) ? b : a);
                end
                3: begin
                    apb_write(3'(2*i), ($signed(a) < $signed(b)) ? b : a);
                    apb_write(3'(2*i + 1), ($signed(a) < $signed(b)) ? a : b);
                end
                4: begin
                    apb_write(3'(2*i), POS_MAX);
                    apb_write(3'(2*i + 1), POS_MIN);
                end
                5: begin
                    apb_write(3'(2*i), a);
                    apb_write(3'(2*i + 1), b);
                end
                default: begin
                    base = $signed(a) >>> 2;
                    apb_write(3'(2*i), base);
                    apb_write(3'(2*i + 1), base + $urandom_range(0, 1 << 20));
                end
            endcase
        end
        if (phase == 2) begin
            apb_write(REG_SPARE_LO, $urandom);
            apb_write(REG_SPARE_HI, $urandom);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_LOAD;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // bounds still at reset: nothing loaded, then scans squeezed to zero
        send_word(op_word(OP_ADVANCE));
        send_word(op_word(OP_UNUSED));
        send_word(op_word(OP_ABORT));
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                drain();
                set_bounds(phase);
            end
            send_idle_pct = (phase <= 2) ? 32 : (phase <= 4) ? 48 : 0;
            recv_idle_pct = (phase <= 2) ? 48 : (phase <= 4) ? 32 : 0;
            if (phase == 1) directed_words();
            while (words_sent < (phase + 1) * WORDS_PER_PHASE) run_sequence();
        end
        drain();

        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
